>>> rtl/hbd_pkg.sv
`timescale 1ns / 1ps

package hbd_pkg;

	// Default sizes of the byte counters and the line counter.
	localparam int COUNT_BITS_DEF = 32;
	localparam int LINE_BITS_DEF  = 16;

	// Result queue depth; one item may push two results.
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [1:0] REG_BODY_MODE   = 2'd0;
	localparam logic [1:0] REG_BODY_LENGTH = 2'd1;
	localparam logic [1:0] REG_MAX_LINE    = 2'd2;
	localparam logic [1:0] REG_MAX_TRAILER = 2'd3;

	// Body modes.
	localparam logic [1:0] MODE_FIXED   = 2'd0;
	localparam logic [1:0] MODE_CHUNKED = 2'd1;

	// Register values after reset.
	localparam logic [1:0]  RST_BODY_MODE   = MODE_CHUNKED;
	localparam logic [31:0] RST_BODY_LENGTH = 32'd0;
	localparam logic [15:0] RST_MAX_LINE    = 16'd16384;
	localparam logic [31:0] RST_MAX_TRAILER = 32'd65536;

	// Characters the parser looks for.
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Input item operations.
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [2:0] {
		KIND_BODY,
		KIND_TBYTE,
		KIND_TEND,
		KIND_DONE,
		KIND_ERR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_LINE_LONG,
		ERR_EMPTY_SIZE,
		ERR_BAD_SIZE,
		ERR_NO_CRLF,
		ERR_NO_COLON,
		ERR_TRAILER_BIG
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		err_t        error_code;
		logic        last;
	} res_t;

	// Up to two results produced by one input item.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic [1:0]  body_mode;
		logic [31:0] body_length;
		logic [15:0] max_line_bytes;
		logic [31:0] max_trailer_bytes;
	} cfg_t;

endpackage

>>> rtl/http_body_dechunker.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    op, in_byte
// result    out        out_valid / out_stall  kind, out_byte, error_code, last_of_run
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// An item is registered on acceptance and parsed once the queue has room for two
// results; its zero, one or two results enter a four-entry result queue and can leave
// in the cycle after. One item is accepted per cycle while in_stall is low; items that
// give two results are limited by the result port: one result per unstalled cycle.
// Reset leaves chunked mode selected and the parser waiting for a size line.
// The input stalls only while the held item waits for two free queue slots.

module http_body_dechunker #(
	parameter int COUNT_BITS = hbd_pkg::COUNT_BITS_DEF,
	parameter int LINE_BITS  = hbd_pkg::LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  error_code,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import hbd_pkg::*;

	cfg_t                 cfg_q;
	logic                 valid_s1;
	logic                 op_s1;
	logic [7:0]           byte_s1;
	logic                 fire;
	logic                 accept;
	logic                 pop;
	push_t                push;
	res_t                 head;
	logic [RES_CNT_W-1:0] count;

	// The held item moves on when the queue can take two results.
	assign fire     = valid_s1 && (count <= RES_CNT_W'(RES_DEPTH - 2));
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.body_mode         <= RST_BODY_MODE;
			cfg_q.body_length       <= RST_BODY_LENGTH;
			cfg_q.max_line_bytes    <= RST_MAX_LINE;
			cfg_q.max_trailer_bytes <= RST_MAX_TRAILER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BODY_MODE:   cfg_q.body_mode         <= cfg_wdata[1:0];
				REG_BODY_LENGTH: cfg_q.body_length       <= cfg_wdata;
				REG_MAX_LINE:    cfg_q.max_line_bytes    <= cfg_wdata[15:0];
				REG_MAX_TRAILER: cfg_q.max_trailer_bytes <= cfg_wdata;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			byte_s1 <= in_byte;
		end
	end

	hbd_parser #(
		.COUNT_BITS (COUNT_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.op      (op_s1),
		.in_byte (byte_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	hbd_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	// Result port.
	assign out_valid   = (count != '0);
	assign pop         = out_valid && !out_stall;
	assign kind        = head.kind;
	assign out_byte    = head.out_byte;
	assign error_code  = head.error_code;
	assign last_of_run = head.last;

`ifndef SYNTH
	// Results are only produced when the queue has room for both.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (count <= RES_CNT_W'(RES_DEPTH - 2)))
		else $error("results pushed into a full queue");

	// A pushed result is offered on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |=> out_valid)
		else $error("pushed result not offered");

	// Only the final result of an item carries the run mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
		else $error("run mark on the wrong result");

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue overflow");
`endif

endmodule

>>> rtl/hbd_result_fifo.sv
`timescale 1ns / 1ps

module hbd_result_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbd_pkg::push_t                push,
	input  logic                          pop,
	output hbd_pkg::res_t                 head,
	output logic [hbd_pkg::RES_CNT_W-1:0] count
);
	import hbd_pkg::*;

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wptr_q;
	logic [RES_PTR_W-1:0] rptr_q;
	logic [RES_CNT_W-1:0] count_q;
	logic [RES_PTR_W-1:0] wptr_n1;

	assign wptr_n1 = wptr_q + RES_PTR_W'(1);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + RES_PTR_W'(push.n);
			if (pop) begin
				rptr_q <= rptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
		end
	end

	// Result storage; the second result of an item goes one slot further on.
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wptr_n1] <= push.r1;
		end
	end

	assign head  = mem_q[rptr_q];
	assign count = count_q;

endmodule

>>> rtl/hbd_parser.sv
`timescale 1ns / 1ps

module hbd_parser #(
	parameter int COUNT_BITS = hbd_pkg::COUNT_BITS_DEF,
	parameter int LINE_BITS  = hbd_pkg::LINE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           op,
	input  logic [7:0]     in_byte,
	input  hbd_pkg::cfg_t  cfg,
	output hbd_pkg::push_t push
);
	import hbd_pkg::*;

	localparam int BL_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam int LC_W  = ((LINE_BITS > 16) ? LINE_BITS : 16) + 1;
	localparam int SUM_W = ((LINE_BITS > 32) ? LINE_BITS : 32) + 2;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_CHUNK,
		PH_CR,
		PH_LF,
		PH_TRAILER,
		PH_FIXED,
		PH_TUNNEL,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic cr;
		logic ext;
		logic digit;
		logic bad;
		logic colon;
	} flags_t;

	phase_t                  phase_q, phase_d;
	logic [COUNT_BITS-1:0]   bytes_left_q, bytes_left_d;
	logic [COUNT_BITS-1:0]   size_accum_q, size_accum_d;
	logic [LINE_BITS-1:0]    line_count_q, line_count_d;
	logic [31:0]             trailer_total_q, trailer_total_d;
	flags_t                  flags_q, flags_d;
	push_t                   push_d;

	// Hex digit decode: valid bit over the nibble value.
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - "0")};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end
		return r;
	endfunction

	// Appends one result to the item's list.
	function automatic push_t add_res(input push_t p, input kind_t k,
			input logic [7:0] b, input err_t e);
		push_t q;
		res_t  r;
		r = '{kind: k, out_byte: b, error_code: e, last: 1'b0};
		q = p;
		if (p.n == 2'd0) begin
			q.r0 = r;
		end else begin
			q.r1 = r;
		end
		q.n = p.n + 2'd1;
		return q;
	endfunction

	// One item's effect on the parsing state.
	always_comb begin
		logic [COUNT_BITS-1:0] bl_dec;
		logic [COUNT_BITS-1:0] start_bl;
		logic [LINE_BITS-1:0]  len;
		logic [SUM_W-1:0]      tsum;
		logic [31:0]           tnew;
		logic [4:0]            hx;
		logic                  too_long;

		phase_d         = phase_q;
		bytes_left_d    = bytes_left_q;
		size_accum_d    = size_accum_q;
		line_count_d    = line_count_q;
		trailer_total_d = trailer_total_q;
		flags_d         = flags_q;
		push_d          = '0;

		bl_dec = (bytes_left_q != '0) ? bytes_left_q - COUNT_BITS'(1) : '0;
		start_bl = (BL_W'(cfg.body_length) > BL_W'({COUNT_BITS{1'b1}})) ?
			{COUNT_BITS{1'b1}} : COUNT_BITS'(cfg.body_length);
		len = line_count_q - LINE_BITS'(flags_q.cr);
		tsum = SUM_W'(trailer_total_q) + SUM_W'(len) + SUM_W'(1);
		tnew = (tsum > SUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tsum[31:0];
		hx = hex_dec(in_byte);
		too_long = (line_count_q == {LINE_BITS{1'b1}}) ||
			(LC_W'(line_count_q) + LC_W'(1) > LC_W'(cfg.max_line_bytes));

		if (step) begin
			if (op == OP_START) begin
				// A start item clears everything and picks the body mode.
				bytes_left_d    = '0;
				trailer_total_d = '0;
				line_count_d    = '0;
				flags_d         = '0;
				size_accum_d    = '0;
				if (cfg.body_mode == MODE_FIXED) begin
					bytes_left_d = start_bl;
					if (start_bl == '0) begin
						phase_d = PH_HALT;
						push_d  = add_res(push_d, KIND_DONE, 8'd0, ERR_NONE);
					end else begin
						phase_d = PH_FIXED;
					end
				end else if (cfg.body_mode == MODE_CHUNKED) begin
					phase_d = PH_SIZE;
				end else begin
					phase_d = PH_TUNNEL;
				end
			end else begin
				unique case (phase_q)
					PH_TUNNEL: begin
						push_d = add_res(push_d, KIND_BODY, in_byte, ERR_NONE);
					end
					PH_FIXED: begin
						push_d = add_res(push_d, KIND_BODY, in_byte, ERR_NONE);
						bytes_left_d = bl_dec;
						if (bl_dec == '0) begin
							phase_d = PH_HALT;
							push_d  = add_res(push_d, KIND_DONE, 8'd0, ERR_NONE);
						end
					end
					PH_CHUNK: begin
						push_d = add_res(push_d, KIND_BODY, in_byte, ERR_NONE);
						bytes_left_d = bl_dec;
						if (bl_dec == '0) begin
							phase_d = PH_CR;
						end
					end
					PH_CR: begin
						if (in_byte == CH_CR) begin
							phase_d = PH_LF;
						end else begin
							phase_d = PH_HALT;
							push_d  = add_res(push_d, KIND_ERR, 8'd0, ERR_NO_CRLF);
						end
					end
					PH_LF: begin
						if (in_byte == CH_LF) begin
							phase_d      = PH_SIZE;
							line_count_d = '0;
							flags_d      = '0;
							size_accum_d = '0;
						end else begin
							phase_d = PH_HALT;
							push_d  = add_res(push_d, KIND_ERR, 8'd0, ERR_NO_CRLF);
						end
					end
					PH_SIZE, PH_TRAILER: begin
						if (in_byte == CH_LF) begin
							// End of a size line or a trailer line.
							if (phase_q == PH_SIZE) begin
								if (len == '0) begin
									phase_d = PH_HALT;
									push_d  = add_res(push_d, KIND_ERR, 8'd0,
										ERR_EMPTY_SIZE);
								end else if (flags_q.bad || !flags_q.digit) begin
									phase_d = PH_HALT;
									push_d  = add_res(push_d, KIND_ERR, 8'd0,
										ERR_BAD_SIZE);
								end else begin
									if (size_accum_q == '0) begin
										phase_d = PH_TRAILER;
									end else begin
										bytes_left_d = size_accum_q;
										phase_d      = PH_CHUNK;
									end
									line_count_d = '0;
									flags_d      = '0;
									size_accum_d = '0;
								end
							end else if (len == '0) begin
								phase_d = PH_HALT;
								push_d  = add_res(push_d, KIND_DONE, 8'd0, ERR_NONE);
							end else if (!flags_q.colon) begin
								phase_d = PH_HALT;
								push_d  = add_res(push_d, KIND_ERR, 8'd0, ERR_NO_COLON);
							end else begin
								trailer_total_d = tnew;
								line_count_d    = '0;
								flags_d         = '0;
								size_accum_d    = '0;
								push_d = add_res(push_d, KIND_TEND, 8'd0, ERR_NONE);
								if (tnew > cfg.max_trailer_bytes) begin
									phase_d = PH_HALT;
									push_d  = add_res(push_d, KIND_ERR, 8'd0,
										ERR_TRAILER_BIG);
								end
							end
						end else if (too_long) begin
							phase_d = PH_HALT;
							push_d  = add_res(push_d, KIND_ERR, 8'd0, ERR_LINE_LONG);
						end else begin
							line_count_d = line_count_q + LINE_BITS'(1);
							flags_d.cr   = (in_byte == CH_CR);
							if (phase_q == PH_TRAILER) begin
								// A held CR not followed by LF belongs to the line.
								if (flags_q.cr) begin
									push_d = add_res(push_d, KIND_TBYTE, CH_CR, ERR_NONE);
								end
								if (in_byte != CH_CR) begin
									push_d = add_res(push_d, KIND_TBYTE, in_byte,
										ERR_NONE);
									if (in_byte == CH_COLON) begin
										flags_d.colon = 1'b1;
									end
								end
							end else if (!flags_q.ext) begin
								// Size digits until the first space.
								if (flags_q.cr) begin
									flags_d.bad = 1'b1;
								end
								if (in_byte == CH_CR) begin
									flags_d.cr = 1'b1;
								end else if (in_byte == CH_SPACE) begin
									flags_d.ext = 1'b1;
								end else if (!hx[4] ||
										size_accum_q[COUNT_BITS-1 -: 4] != 4'd0) begin
									flags_d.bad = 1'b1;
								end else begin
									size_accum_d  = {size_accum_q[COUNT_BITS-5:0], hx[3:0]};
									flags_d.digit = 1'b1;
								end
							end
						end
					end
					PH_HALT: begin
						phase_d = PH_HALT;
					end
				endcase
			end
		end

		// Mark the final result of this item.
		if (push_d.n == 2'd1) begin
			push_d.r0.last = 1'b1;
		end else if (push_d.n == 2'd2) begin
			push_d.r1.last = 1'b1;
		end
	end

	// Parsing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SIZE;
			bytes_left_q    <= '0;
			size_accum_q    <= '0;
			line_count_q    <= '0;
			trailer_total_q <= '0;
			flags_q         <= '0;
		end else begin
			phase_q         <= phase_d;
			bytes_left_q    <= bytes_left_d;
			size_accum_q    <= size_accum_d;
			line_count_q    <= line_count_d;
			trailer_total_q <= trailer_total_d;
			flags_q         <= flags_d;
		end
	end

	assign push = push_d;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import hbd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_PRINTED    = 100;

	localparam logic [1:0] MODE_TUNNEL     = 2'd2;
	localparam logic [1:0] MODE_TUNNEL_ALT = 2'd3;

	// Characters used to build size lines and trailers.
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_UPPER_G = 8'h47;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	typedef enum logic [2:0] {
		P_SIZE_LINE,
		P_CHUNK_DATA,
		P_EXPECT_CR,
		P_EXPECT_LF,
		P_TRAILER,
		P_FIXED_DATA,
		P_TUNNEL,
		P_HALTED
	} parse_phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} stim_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [2:0]  error_code;
	logic        last_of_run;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	http_body_dechunker uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.error_code  (error_code),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	// Stimulus and expectation stores.
	stim_item_t pending_items[$];
	res_t       expected_results[$];
	logic [7:0] body_buf[$];
	stim_item_t drv_item;
	res_t       exp_res;
	int         items_seen = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;
	int         phase_items = 0;

	// Run statistics.
	int err_count = 0;
	int quiet_cycles = 0;
	int n_items = 0;
	int n_starts = 0;
	int n_results = 0;
	int n_done = 0;
	int n_err = 0;
	int n_tend = 0;

	// Predictor registers, at their reset values.
	logic [1:0]   m_mode = RST_BODY_MODE;
	logic [31:0]  m_len = RST_BODY_LENGTH;
	logic [15:0]  m_max_line = RST_MAX_LINE;
	logic [31:0]  m_max_trailer = RST_MAX_TRAILER;

	// Predictor parse state.
	parse_phase_t ph = P_SIZE_LINE;
	logic [31:0]  chunk_left = '0;
	logic [31:0]  size_acc = '0;
	logic [15:0]  line_len = '0;
	logic [31:0]  trailer_sum = '0;
	logic         held_cr = 1'b0;
	logic         in_ext = 1'b0;
	logic         digit_seen = 1'b0;
	logic         bad_size = 1'b0;
	logic         colon_seen = 1'b0;

	// Results of the item being predicted.
	res_t step_res[2];
	int   step_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------
	// Predictor of the decoder.
	// ---------------------------------------------------------------

	function automatic void expect_result(kind_t k, logic [7:0] b, err_t e);
		res_t r;
		r.kind = k;
		r.out_byte = b;
		r.error_code = e;
		r.last = 1'b0;
		step_res[step_count] = r;
		step_count++;
	endfunction

	function automatic void halt_with(err_t e);
		ph = P_HALTED;
		expect_result(KIND_ERR, 8'h00, e);
	endfunction

	function automatic void clear_line();
		line_len = '0;
		size_acc = '0;
		held_cr = 1'b0;
		in_ext = 1'b0;
		digit_seen = 1'b0;
		bad_size = 1'b0;
		colon_seen = 1'b0;
	endfunction

	function automatic int hex_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	// One character of a line, after line end handling.
	function automatic void line_char(logic [7:0] c);
		int d;
		if (ph == P_TRAILER) begin
			expect_result(KIND_TBYTE, c, ERR_NONE);
			if (c == CH_COLON) colon_seen = 1'b1;
			return;
		end
		if (in_ext) return;
		if (c == CH_SPACE) begin
			in_ext = 1'b1;
			return;
		end
		d = hex_val(c);
		if (d < 0 || size_acc[31:28] != 4'd0) begin
			bad_size = 1'b1;
		end else begin
			size_acc = {size_acc[27:0], d[3:0]};
			digit_seen = 1'b1;
		end
	endfunction

	// The LF of a size line or trailer line.
	function automatic void line_end();
		logic [15:0] len;
		logic [32:0] sum;
		len = line_len - (held_cr ? 16'd1 : 16'd0);
		if (ph == P_SIZE_LINE) begin
			if (len == 16'd0) begin
				halt_with(ERR_EMPTY_SIZE);
				return;
			end
			if (bad_size || !digit_seen) begin
				halt_with(ERR_BAD_SIZE);
				return;
			end
			if (size_acc == 32'd0) begin
				ph = P_TRAILER;
			end else begin
				chunk_left = size_acc;
				ph = P_CHUNK_DATA;
			end
			clear_line();
			return;
		end
		if (len == 16'd0) begin
			ph = P_HALTED;
			expect_result(KIND_DONE, 8'h00, ERR_NONE);
			return;
		end
		if (!colon_seen) begin
			halt_with(ERR_NO_COLON);
			return;
		end
		sum = {1'b0, trailer_sum} + {17'd0, len} + 33'd1;
		trailer_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		clear_line();
		expect_result(KIND_TEND, 8'h00, ERR_NONE);
		if (trailer_sum > m_max_trailer) halt_with(ERR_TRAILER_BIG);
	endfunction

	function automatic void line_byte(logic [7:0] c);
		if (c == CH_LF) begin
			line_end();
			return;
		end
		if (line_len == 16'hFFFF || ({1'b0, line_len} + 17'd1) > {1'b0, m_max_line}) begin
			halt_with(ERR_LINE_LONG);
			return;
		end
		line_len++;
		// A CR that was not followed by LF belongs to the line.
		if (held_cr) begin
			held_cr = 1'b0;
			line_char(CH_CR);
		end
		if (c == CH_CR) held_cr = 1'b1;
		else line_char(c);
	endfunction

	// Works out the results of one accepted item and queues them.
	function automatic void dechunk_item(logic item_op, logic [7:0] c);
		res_t r;
		step_count = 0;
		if (item_op == OP_START) begin
			chunk_left = '0;
			trailer_sum = '0;
			clear_line();
			if (m_mode == MODE_FIXED) begin
				chunk_left = m_len;
				if (chunk_left == 32'd0) begin
					ph = P_HALTED;
					expect_result(KIND_DONE, 8'h00, ERR_NONE);
				end else begin
					ph = P_FIXED_DATA;
				end
			end else if (m_mode == MODE_CHUNKED) begin
				ph = P_SIZE_LINE;
			end else begin
				ph = P_TUNNEL;
			end
		end else begin
			case (ph)
				P_TUNNEL: expect_result(KIND_BODY, c, ERR_NONE);
				P_FIXED_DATA: begin
					expect_result(KIND_BODY, c, ERR_NONE);
					if (chunk_left != 32'd0) chunk_left--;
					if (chunk_left == 32'd0) begin
						ph = P_HALTED;
						expect_result(KIND_DONE, 8'h00, ERR_NONE);
					end
				end
				P_CHUNK_DATA: begin
					expect_result(KIND_BODY, c, ERR_NONE);
					if (chunk_left != 32'd0) chunk_left--;
					if (chunk_left == 32'd0) ph = P_EXPECT_CR;
				end
				P_EXPECT_CR: begin
					if (c == CH_CR) ph = P_EXPECT_LF;
					else halt_with(ERR_NO_CRLF);
				end
				P_EXPECT_LF: begin
					if (c == CH_LF) begin
						ph = P_SIZE_LINE;
						clear_line();
					end else begin
						halt_with(ERR_NO_CRLF);
					end
				end
				P_SIZE_LINE, P_TRAILER: line_byte(c);
				default: ;
			endcase
		end
		for (int i = 0; i < step_count; i++) begin
			r = step_res[i];
			r.last = (i == step_count - 1);
			expected_results.insert(expected_results.size(), r);
		end
	endfunction

	// ---------------------------------------------------------------
	// Driver: presents pending items and drives the result stall.
	// ---------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_BYTE;
			in_byte <= 8'h00;
			out_stall <= 1'b0;
		end else begin
			// A new item goes out once the previous one has been taken.
			if (!in_valid || n_items != items_seen) begin
				items_seen = n_items;
				if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
					drv_item = pending_items[0];
					pending_items.delete(0);
					in_valid <= 1'b1;
					op <= drv_item.op;
					in_byte <= drv_item.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// Monitor: tracks register writes, predicts accepted items and
	// checks every accepted result against the oldest expectation.
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BODY_MODE:   m_mode = cfg_wdata[1:0];
					REG_BODY_LENGTH: m_len = cfg_wdata;
					REG_MAX_LINE:    m_max_line = cfg_wdata[15:0];
					REG_MAX_TRAILER: m_max_trailer = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected result kind %0d byte %02h code %0d last %0b",
						kind, out_byte, error_code, last_of_run));
				end else begin
					exp_res = expected_results[0];
					expected_results.delete(0);
					if (kind !== exp_res.kind || out_byte !== exp_res.out_byte ||
					    error_code !== exp_res.error_code || last_of_run !== exp_res.last)
						report_mismatch($sformatf({"result %0d: got kind %0d byte %02h ",
							"code %0d last %0b, want %0d %02h %0d %0b"},
							n_results, kind, out_byte, error_code, last_of_run,
							exp_res.kind, exp_res.out_byte, exp_res.error_code, exp_res.last));
					if (exp_res.kind == KIND_DONE) n_done++;
					if (exp_res.kind == KIND_ERR) n_err++;
					if (exp_res.kind == KIND_TEND) n_tend++;
				end
			end
			if (in_valid && !in_stall) begin
				n_items++;
				if (op == OP_START) n_starts++;
				dechunk_item(op, in_byte);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus construction.
	// ---------------------------------------------------------------

	function automatic void push_raw(logic [7:0] b);
		body_buf.insert(body_buf.size(), b);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_raw(s[i]);
	endfunction

	function automatic void push_crlf();
		push_raw(CH_CR);
		push_raw(CH_LF);
	endfunction

	// Line end with or without the optional CR.
	function automatic void push_eol();
		if ($urandom_range(1) != 0) push_raw(CH_CR);
		push_raw(CH_LF);
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] v, bit upper);
		if (v < 4'd10) return CH_ZERO + {4'd0, v};
		return (upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, v - 4'd10};
	endfunction

	// Bytes biased towards those that steer the parser.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		case ($urandom_range(13))
			0: b = CH_CR;
			1: b = CH_LF;
			2: b = CH_SPACE;
			3: b = CH_COLON;
			4: b = CH_ZERO;
			5: b = CH_LOWER_A;
			6: b = CH_UPPER_G;
			default: ;
		endcase
		return b;
	endfunction

	// Moves the buffered body, behind a start item, into the pending items.
	function automatic void flush_body();
		stim_item_t it;
		it.op = OP_START;
		it.data = 8'($urandom_range(255));
		pending_items.insert(pending_items.size(), it);
		phase_items++;
		foreach (body_buf[i]) begin
			it.op = OP_BYTE;
			it.data = body_buf[i];
			pending_items.insert(pending_items.size(), it);
			phase_items++;
		end
		body_buf.delete();
	endfunction

	function automatic void push_size_line(logic [31:0] v, int digits);
		bit upper;
		upper = 1'($urandom_range(1));
		repeat ($urandom_range(2)) push_raw(CH_ZERO);
		for (int i = digits - 1; i >= 0; i--) push_raw(hex_digit(v[4*i +: 4], upper));
		if ($urandom_range(3) == 0) begin
			push_raw(CH_SPACE);
			push_text("ext=1");
		end
		push_eol();
	endfunction

	// A well-formed chunked body with random content, sometimes broken.
	function automatic void build_chunked();
		int nchunks;
		int sz;
		int pick;
		int cut;
		nchunks = $urandom_range(3);
		repeat (nchunks) begin
			sz = $urandom_range(1, 12);
			pick = $urandom_range(99);
			if (pick < 5) begin
				// Nine digits cannot fit the counter.
				push_raw(CH_ZERO + 8'd1);
				push_size_line($urandom, 8);
			end else if (pick < 8) begin
				push_size_line($urandom | 32'h1000_0000, 8);
			end else begin
				push_size_line(sz, 1);
			end
			repeat (sz) push_raw(8'($urandom_range(255)));
			push_crlf();
		end
		push_size_line(32'd0, 1);
		repeat ($urandom_range(2)) begin
			repeat ($urandom_range(1, 4)) push_raw(8'(CH_LOWER_A + $urandom_range(25)));
			if ($urandom_range(9) != 0) push_raw(CH_COLON);
			repeat ($urandom_range(5)) push_raw(8'($urandom_range(8'h20, 8'h7E)));
			if ($urandom_range(5) == 0) begin
				push_raw(CH_CR);
				push_raw(CH_UPPER_G);
			end
			push_eol();
		end
		push_eol();
		// Damage some bodies: one wrong byte, or cut short.
		pick = $urandom_range(99);
		if (pick < 15) begin
			body_buf[$urandom_range(body_buf.size() - 1)] = noise_byte();
		end else if (pick < 25) begin
			cut = $urandom_range(body_buf.size() - 1);
			while (body_buf.size() > cut) body_buf.delete(body_buf.size() - 1);
		end
	endfunction

	function automatic void gen_body(logic [1:0] mode, logic [31:0] len);
		int n;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 12)) push_raw(noise_byte());
		end else if (mode == MODE_CHUNKED) begin
			build_chunked();
		end else if (mode == MODE_FIXED) begin
			if (len > 32'd32) begin
				n = $urandom_range(1, 12);
			end else begin
				n = len;
				if ($urandom_range(3) == 0) n = n + int'($urandom_range(4)) - 2;
				if (n < 0) n = 0;
			end
			repeat (n) push_raw(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(12)) push_raw(8'($urandom_range(255)));
		end
		flush_body();
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every item has gone in and every result has come out,
	// then lets the pipeline settle for items that give no result.
	task automatic wait_quiet();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(logic [1:0] mode, logic [31:0] len, logic [15:0] max_line,
	                         logic [31:0] max_trailer, int gap, int stall, int budget);
		write_reg(REG_BODY_MODE, {30'd0, mode});
		write_reg(REG_BODY_LENGTH, len);
		write_reg(REG_MAX_LINE, {16'd0, max_line});
		write_reg(REG_MAX_TRAILER, max_trailer);
		gap_pct = gap;
		stall_pct = stall;
		phase_items = 0;
		while (phase_items < budget) gen_body(mode, len);
		wait_quiet();
	endtask

	// ---------------------------------------------------------------
	// Test sequence.
	// ---------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BODY_MODE;
		cfg_wdata = 32'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed bodies at the reset settings: one chunk with an extension
		// and extreme data bytes, a trailer and the closing empty line; an
		// empty size line; a stray CR inside a size line.
		push_text("2 ext");
		push_crlf();
		push_raw(8'h00);
		push_raw(8'hFF);
		push_crlf();
		push_text("0");
		push_crlf();
		push_text("a:");
		push_crlf();
		push_crlf();
		flush_body();
		push_raw(CH_LF);
		flush_body();
		push_raw(CH_UPPER_F);
		push_raw(CH_CR);
		push_text("x");
		push_raw(CH_LF);
		flush_body();
		wait_quiet();

		// Random bodies over a range of settings and idle patterns.
		run_phase(MODE_CHUNKED, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 350);
		run_phase(MODE_CHUNKED, $urandom, 16'($urandom_range(4, 12)), $urandom_range(1, 40),
			78, 0, 300);
		run_phase(MODE_CHUNKED, 32'd5, 16'd1, 32'd1, 0, 78, 80);
		run_phase(MODE_FIXED, 32'd0, RST_MAX_LINE, RST_MAX_TRAILER, 12, 12, 40);
		run_phase(MODE_FIXED, 32'hFFFF_FFFF, 16'd7, 32'd9, 78, 0, 80);
		run_phase(MODE_FIXED, 32'd1, 16'd100, 32'd100, 0, 78, 100);
		run_phase(MODE_FIXED, $urandom_range(2, 9), 16'd100, 32'd100, 0, 78, 150);
		run_phase(MODE_TUNNEL, 32'd3, 16'd2, 32'd2, 78, 0, 150);
		run_phase(MODE_TUNNEL_ALT, 32'd0, 16'd2, 32'd2, 12, 12, 100);
		run_phase(MODE_CHUNKED, 32'd2, 16'($urandom_range(8, 40)), $urandom_range(16, 200),
			12, 12, 400);
		run_phase(MODE_CHUNKED, 32'd0, RST_MAX_LINE, RST_MAX_TRAILER, 0, 78, 200);

		$display("Covered %0d items in %0d bodies across fixed, chunked and tunnel modes,",
			n_items, n_starts);
		$display("checking %0d results: %0d completions, %0d errors, %0d trailer line ends.",
			n_results, n_done, n_err, n_tend);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
